// ===== src/lpwc_pkg.sv =====
// shared constants and types for the line printer word controller
`default_nettype none

package lpwc_pkg;

    localparam int CHAR_W     = 7;
    localparam int WORD_W     = 36;
    localparam int STATUS_W   = 12;
    localparam int LEVEL_W    = 3;
    localparam int REQ_W      = 3;
    localparam int NUM_CHARS  = 5;
    localparam int LEFT_W     = 21;
    localparam int RIGHT_W    = 14;
    localparam int POS_W      = 3;

    localparam logic [REQ_W-1:0] REQ_STATUS_READ  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CONTROL_WR   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DATA_WR      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DATA_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PRINT_TICK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_ATTACH       = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DETACH       = 3'd6;

    localparam int CTL_DONE_BIT  = 6;
    localparam int CTL_BUSY_BIT  = 7;
    localparam int CTL_CLEAR_BIT = 10;
    localparam int ERR_LEVEL_LSB = 3;

    localparam logic [CHAR_W-1:0] CHAR_LC_A   = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 7'h7a;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'h20;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [LEVEL_W-1:0] level_t;

    function automatic char_t fold_case(input char_t c, input logic upper);
        char_t r;
        r = c;
        if (upper && c >= CHAR_LC_A && c <= CHAR_LC_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lpwc_ifs.sv =====
// request, result and configuration channel interfaces
`default_nettype none

interface lpwc_in_if;
    logic                       valid;
    logic                       ready;
    logic [lpwc_pkg::REQ_W-1:0]  req_type;
    logic [lpwc_pkg::WORD_W-1:0] bus_data;
    logic [lpwc_pkg::POS_W-1:0]  fault_pos;

    modport source (output valid, output req_type, output bus_data, output fault_pos,
                    input ready);
    modport sink (input valid, input req_type, input bus_data, input fault_pos,
                  output ready);
endinterface

interface lpwc_out_if;
    logic                         valid;
    logic                         ready;
    logic [lpwc_pkg::STATUS_W-1:0] read_data;
    logic                         char_valid;
    logic [lpwc_pkg::CHAR_W-1:0]   print_char;
    logic                         irq_request;
    logic [lpwc_pkg::LEVEL_W-1:0]  irq_level;
    logic                         last;

    modport source (output valid, output read_data, output char_valid, output print_char,
                    output irq_request, output irq_level, output last, input ready);
    modport sink (input valid, input read_data, input char_valid, input print_char,
                  input irq_request, input irq_level, input last, output ready);
endinterface

interface lpwc_cfg_if;
    logic valid;
    logic ready;
    logic uppercase_mode;

    modport source (output valid, output uppercase_mode, input ready);
    modport sink (input valid, input uppercase_mode, output ready);
endinterface

`default_nettype wire

// ===== src/line_printer_word_controller_core.sv =====
// top level: register accesses, print unpack and result sequencing
// the first result is offered in the cycle after a request is accepted
// a request that prints n characters yields n+1 results, one per cycle while the output is ready
// a new request is taken in the cycle the previous one's last result leaves
// throughput: one request per cycle when no characters are printed and the output is ready
// reset clears flags, levels, held word, interrupt state and uppercase mode
`default_nettype none

module line_printer_word_controller_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpwc_in_if.sink     in_ch,
    lpwc_out_if.source  out_ch,
    lpwc_cfg_if.sink    cfg
);
    import lpwc_pkg::*;

    // controller state
    logic                  upper_reg;
    level_t                done_level_reg, done_level_next;
    level_t                err_level_reg, err_level_next;
    logic                  done_flag_reg, done_flag_next;
    logic                  busy_flag_reg, busy_flag_next;
    logic                  err_flag_reg, err_flag_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [RIGHT_W-1:0]    right_reg, right_next;
    logic                  armed_reg, armed_next;
    logic                  attached_reg, attached_next;
    logic                  irq_reg, irq_next;
    level_t                irq_level_reg, irq_level_next;

    // result buffer
    logic                  buf_valid_reg;
    logic [NUM_CHARS-1:0]  mask_reg, mask_next;
    char_t                 chars_reg [NUM_CHARS];
    char_t                 chars_next [NUM_CHARS];
    logic                  pre_irq_reg;
    level_t                pre_level_reg;
    logic                  post_irq_reg;
    level_t                post_level_reg;
    logic [STATUS_W-1:0]   rd_reg, rd_next;

    logic                  in_fire;
    logic                  out_fire;
    logic [STATUS_W-1:0]   status;
    char_t                 raw [NUM_CHARS];
    logic [NUM_CHARS-1:0]  nz;
    logic [POS_W-1:0]      rank [NUM_CHARS];
    logic                  fault;
    logic [POS_W-1:0]      sel;
    logic [NUM_CHARS-1:0]  mask_cleared;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = !buf_valid_reg || (out_ch.ready && mask_reg == '0);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_ch.valid && out_ch.ready;

    assign status = {1'b0, !upper_reg, 1'b0, err_flag_reg || !attached_reg,
                     busy_flag_reg, done_flag_reg, err_level_reg, done_level_reg};

    // unpack the held word and rank the nonzero characters
    always_comb
    begin
        logic [POS_W-1:0] cnt;
        raw[0] = left_reg[20:14];
        raw[1] = left_reg[13:7];
        raw[2] = left_reg[6:0];
        raw[3] = right_reg[13:7];
        raw[4] = right_reg[6:0];
        cnt = '0;
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            nz[i]   = raw[i] != '0;
            rank[i] = cnt;
            cnt     = cnt + POS_W'(nz[i]);
        end
        fault = cnt > in_ch.fault_pos;
    end

    // next state for one request
    always_comb
    begin
        done_level_next = done_level_reg;
        err_level_next  = err_level_reg;
        done_flag_next  = done_flag_reg;
        busy_flag_next  = busy_flag_reg;
        err_flag_next   = err_flag_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        armed_next      = armed_reg;
        attached_next   = attached_reg;
        irq_next        = irq_reg;
        irq_level_next  = irq_level_reg;
        mask_next       = '0;
        rd_next         = '0;
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            chars_next[i] = fold_case(raw[i], upper_reg);
        end

        case (in_ch.req_type)
            REQ_STATUS_READ:
            begin
                rd_next = status;
            end
            REQ_CONTROL_WR:
            begin
                irq_next        = 1'b0;
                irq_level_next  = '0;
                done_level_next = in_ch.bus_data[LEVEL_W-1:0];
                err_level_next  = in_ch.bus_data[ERR_LEVEL_LSB +: LEVEL_W];
                done_flag_next  = in_ch.bus_data[CTL_DONE_BIT];
                busy_flag_next  = in_ch.bus_data[CTL_BUSY_BIT];
                err_flag_next   = 1'b0;
                if (in_ch.bus_data[CTL_CLEAR_BIT])
                begin
                    left_next      = '0;
                    right_next     = '0;
                    busy_flag_next = 1'b1;
                    armed_next     = 1'b1;
                end
                if (!attached_reg && err_level_next != '0)
                begin
                    irq_next       = 1'b1;
                    irq_level_next = err_level_next;
                end
                if (done_flag_next && done_level_next != '0)
                begin
                    irq_next       = 1'b1;
                    irq_level_next = done_level_next;
                end
            end
            REQ_DATA_WR:
            begin
                if (!busy_flag_reg)
                begin
                    left_next      = in_ch.bus_data[35:15];
                    right_next     = in_ch.bus_data[14:1];
                    busy_flag_next = 1'b1;
                    done_flag_next = 1'b0;
                    irq_next       = 1'b0;
                    irq_level_next = '0;
                    armed_next     = 1'b1;
                end
            end
            REQ_DATA_READ:
            begin
            end
            REQ_PRINT_TICK:
            begin
                if (armed_reg)
                begin
                    armed_next = 1'b0;
                    if (!attached_reg)
                    begin
                        err_flag_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_CHARS; i++)
                        begin
                            mask_next[i] = nz[i] && (rank[i] < in_ch.fault_pos);
                        end
                        if (fault)
                        begin
                            err_flag_next = 1'b1;
                            if (err_level_reg != '0)
                            begin
                                irq_next       = 1'b1;
                                irq_level_next = err_level_reg;
                            end
                        end
                        else
                        begin
                            busy_flag_next = 1'b0;
                            done_flag_next = 1'b1;
                            if (done_level_reg != '0)
                            begin
                                irq_next       = 1'b1;
                                irq_level_next = done_level_reg;
                            end
                        end
                    end
                end
            end
            REQ_ATTACH:
            begin
                attached_next  = 1'b1;
                err_flag_next  = 1'b0;
                irq_next       = 1'b0;
                irq_level_next = '0;
            end
            REQ_DETACH:
            begin
                err_flag_next = 1'b1;
                if (err_level_reg != '0)
                begin
                    irq_next       = 1'b1;
                    irq_level_next = err_level_reg;
                end
                attached_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // lowest pending character in the buffer
    always_comb
    begin
        sel = '0;
        for (int i = NUM_CHARS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = POS_W'(i);
            end
        end
        mask_cleared      = mask_reg;
        mask_cleared[sel] = 1'b0;
    end

    always_comb
    begin
        out_ch.valid = buf_valid_reg;
        if (mask_reg != '0)
        begin
            out_ch.read_data   = '0;
            out_ch.char_valid  = 1'b1;
            out_ch.print_char  = chars_reg[sel];
            out_ch.irq_request = pre_irq_reg;
            out_ch.irq_level   = pre_level_reg;
            out_ch.last        = 1'b0;
        end
        else
        begin
            out_ch.read_data   = rd_reg;
            out_ch.char_valid  = 1'b0;
            out_ch.print_char  = '0;
            out_ch.irq_request = post_irq_reg;
            out_ch.irq_level   = post_level_reg;
            out_ch.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg      <= 1'b0;
            done_level_reg <= '0;
            err_level_reg  <= '0;
            done_flag_reg  <= 1'b0;
            busy_flag_reg  <= 1'b0;
            err_flag_reg   <= 1'b0;
            left_reg       <= '0;
            right_reg      <= '0;
            armed_reg      <= 1'b0;
            attached_reg   <= 1'b0;
            irq_reg        <= 1'b0;
            irq_level_reg  <= '0;
            buf_valid_reg  <= 1'b0;
            mask_reg       <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                upper_reg <= cfg.uppercase_mode;
            end
            if (in_fire)
            begin
                done_level_reg <= done_level_next;
                err_level_reg  <= err_level_next;
                done_flag_reg  <= done_flag_next;
                busy_flag_reg  <= busy_flag_next;
                err_flag_reg   <= err_flag_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
                armed_reg      <= armed_next;
                attached_reg   <= attached_next;
                irq_reg        <= irq_next;
                irq_level_reg  <= irq_level_next;
                buf_valid_reg  <= 1'b1;
                mask_reg       <= mask_next;
            end
            else if (out_fire)
            begin
                if (mask_reg != '0)
                begin
                    mask_reg <= mask_cleared;
                end
                else
                begin
                    buf_valid_reg <= 1'b0;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < NUM_CHARS; i++)
            begin
                chars_reg[i] <= chars_next[i];
            end
            pre_irq_reg    <= irq_reg;
            pre_level_reg  <= irq_level_reg;
            post_irq_reg   <= irq_next;
            post_level_reg <= irq_level_next;
            rd_reg         <= rd_next;
        end
    end

endmodule

`default_nettype wire
